@@ design/mstk_pkg.sv @@
// mstk_pkg: shared types and constants for the max stack.
// Request and status codes, the stack entry and the cell control word.
// No dependencies.
package mstk_pkg;

   localparam int DATA_W = 32;
   localparam int KIND_W = 3;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 7;

   localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [KIND_W-1:0] {
      REQ_PUSH     = 3'd0,
      REQ_POP      = 3'd1,
      REQ_PEEK_TOP = 3'd2,
      REQ_PEEK_MAX = 3'd3,
      REQ_POP_MAX  = 3'd4
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DOWN,
      SEQ_UP,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_DOWN,
      CELL_UP
   } cell_mode_type;

   // one stack slot: its value and the max of itself and everything below
   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] mx;
   } entry_type;

   typedef struct packed {
      cell_mode_type            mode;
      logic                     bottom;
      logic signed [DATA_W-1:0] maxv;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_data_type;

endpackage

@@ design/mstk_if.sv @@
// mstk_if: valid/ready channel interfaces for request and response items.
// Payload widths come from mstk_pkg.
interface mstk_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [mstk_pkg::KIND_W-1:0]            req_type;
   logic signed [mstk_pkg::DATA_W-1:0]     push_value;

   modport source (output valid, req_type, push_value, input ready);
   modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface mstk_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [mstk_pkg::DATA_W-1:0]     result_value;
   logic [mstk_pkg::STAT_W-1:0]            status;
   logic [mstk_pkg::OCC_W-1:0]             occupancy;

   modport source (output valid, result_value, status, occupancy, input ready);
   modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

@@ design/max_stack_top.sv @@
// max_stack_top: bounded signed max stack as a row of cells, top of stack in cell 0.
// Uses mstk_pkg, mstk_if, mstk_cell.
// Push, pop, peeks, pop-max on empty: result is registered, then moved to the response register.
// Pop-max: a slot pointer walks the row down (delete, close the gap) then up (rebuild
//   maxima). No request is taken until the result is loaded; a held result stalls input.
// Reset (synchronous) empties the stack; slot contents are not cleared.
module max_stack_top #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   mstk_req_if.sink    req_if,
   mstk_rsp_if.source  rsp_if
);

   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   // sequencer state
   mstk_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [IDX_W-1:0]        ptr_ff, ptr_in;
   logic signed [mstk_pkg::DATA_W-1:0] max_ff, max_in;
   mstk_pkg::rsp_data_type  pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mstk_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;

   // cell row
   mstk_pkg::entry_type     ent [STACK_DEPTH];
   logic                    del [STACK_DEPTH];
   mstk_pkg::entry_type     push_ent;
   mstk_pkg::cell_ctrl_type ctrl;

   mstk_pkg::req_kind_type  kind;
   logic                    accept;
   logic                    empty;
   logic                    full;
   logic                    down_end;
   logic                    rsp_load;

   assign kind     = mstk_pkg::req_kind_type'(req_if.req_type);
   assign accept   = req_if.valid && req_if.ready;
   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == CNT_W'(STACK_DEPTH));
   assign down_end = (ptr_ff == IDX_W'(fill_ff));
   assign rsp_load = (state_ff == mstk_pkg::SEQ_DONE) && (!rsp_valid_ff || rsp_if.ready);

   // new top entry: its max covers the old top's max unless stack was empty
   always_comb begin
      push_ent.val = req_if.push_value;
      push_ent.mx  = (empty || (req_if.push_value > ent[0].mx)) ? req_if.push_value
                                                                 : ent[0].mx;
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mstk_pkg::SEQ_IDLE: begin
            if (accept) begin
               if ((kind == mstk_pkg::REQ_POP_MAX) && !empty) begin
                  state_in = mstk_pkg::SEQ_DOWN;
               end else begin
                  state_in = mstk_pkg::SEQ_DONE;
               end
            end
         end
         mstk_pkg::SEQ_DOWN: begin
            if (down_end) begin
               state_in = empty ? mstk_pkg::SEQ_DONE : mstk_pkg::SEQ_UP;
            end
         end
         mstk_pkg::SEQ_UP: begin
            if (ptr_ff == '0) begin
               state_in = mstk_pkg::SEQ_DONE;
            end
         end
         mstk_pkg::SEQ_DONE: begin
            if (rsp_load) begin
               state_in = mstk_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = mstk_pkg::SEQ_IDLE;
         end
      endcase
   end

   // ---------------- outputs: handshake and cell control ----------------
   always_comb begin
      req_if.ready = (state_ff == mstk_pkg::SEQ_IDLE);
      ctrl.mode    = mstk_pkg::CELL_HOLD;
      ctrl.bottom  = 1'b0;
      ctrl.maxv    = max_ff;
      unique case (state_ff)
         mstk_pkg::SEQ_IDLE: begin
            if (accept) begin
               if ((kind == mstk_pkg::REQ_PUSH) && !full) begin
                  ctrl.mode = mstk_pkg::CELL_PUSH;
               end else if ((kind == mstk_pkg::REQ_POP) && !empty) begin
                  ctrl.mode = mstk_pkg::CELL_POP;
               end
            end
         end
         mstk_pkg::SEQ_DOWN: begin
            ctrl.mode = mstk_pkg::CELL_DOWN;
         end
         mstk_pkg::SEQ_UP: begin
            ctrl.mode   = mstk_pkg::CELL_UP;
            ctrl.bottom = (ptr_ff == IDX_W'(fill_ff - CNT_W'(1)));
         end
         mstk_pkg::SEQ_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------- request datapath ----------------
   // every result is known at accept; pop-max only reshapes the row after
   always_comb begin
      fill_in = fill_ff;
      max_in  = max_ff;
      pend_in = pend_ff;
      ptr_in  = ptr_ff;
      unique case (state_ff)
         mstk_pkg::SEQ_IDLE: begin
            if (accept) begin
               ptr_in               = '0;
               pend_in.result_value = '0;
               pend_in.status       = mstk_pkg::STAT_OK;
               unique case (kind)
                  mstk_pkg::REQ_PUSH: begin
                     if (full) begin
                        pend_in.status = mstk_pkg::STAT_FULL;
                     end else begin
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  mstk_pkg::REQ_POP, mstk_pkg::REQ_PEEK_TOP,
                  mstk_pkg::REQ_PEEK_MAX, mstk_pkg::REQ_POP_MAX: begin
                     if (empty) begin
                        pend_in.result_value = mstk_pkg::INT_MIN;
                        pend_in.status       = mstk_pkg::STAT_EMPTY;
                     end else if (kind == mstk_pkg::REQ_POP) begin
                        pend_in.result_value = ent[0].val;
                        fill_in              = fill_ff - CNT_W'(1);
                     end else if (kind == mstk_pkg::REQ_PEEK_TOP) begin
                        pend_in.result_value = ent[0].val;
                     end else if (kind == mstk_pkg::REQ_PEEK_MAX) begin
                        pend_in.result_value = ent[0].mx;
                     end else begin
                        pend_in.result_value = ent[0].mx;
                        max_in               = ent[0].mx;
                        fill_in              = fill_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
               pend_in.occupancy = mstk_pkg::OCC_W'(fill_in);
            end
         end
         mstk_pkg::SEQ_DOWN: begin
            // down walk covers slots 0..new fill, then rebuild from new bottom
            if (down_end) begin
               ptr_in = IDX_W'(fill_ff - CNT_W'(1));
            end else begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
         end
         mstk_pkg::SEQ_UP: begin
            ptr_in = ptr_ff - IDX_W'(1);
         end
         mstk_pkg::SEQ_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mstk_pkg::SEQ_IDLE;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff      <= max_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_value = rsp_data_ff.result_value;
   assign rsp_if.status       = rsp_data_ff.status;
   assign rsp_if.occupancy    = rsp_data_ff.occupancy;

   // ---------------- cell row ----------------
   // cell 0 is the top; cell i+1 holds the entry pushed before cell i
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      mstk_pkg::entry_type cell_above;
      mstk_pkg::entry_type cell_below;
      logic                cell_del_above;

      if (i == 0) begin : g_top
         assign cell_above     = push_ent;
         assign cell_del_above = 1'b0;
      end else begin : g_mid
         assign cell_above     = ent[i-1];
         assign cell_del_above = del[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         // nothing below the last slot; it only ever moves into unused space
         assign cell_below = ent[i];
      end else begin : g_inner
         assign cell_below = ent[i+1];
      end

      mstk_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .ptr       (ptr_ff),
         .above     (cell_above),
         .del_above (cell_del_above),
         .below     (cell_below),
         .ent       (ent[i]),
         .del       (del[i])
      );
   end

endmodule

@@ design/mstk_cell.sv @@
// mstk_cell: one slot of the stack row; shifts with its neighbors and
// takes part in the pop-max delete and max-rebuild walks. Uses mstk_pkg.
module mstk_cell #(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mstk_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]        ptr,
   input  mstk_pkg::entry_type     above,
   input  logic                    del_above,
   input  mstk_pkg::entry_type     below,
   output mstk_pkg::entry_type     ent,
   output logic                    del
);

   mstk_pkg::entry_type ent_ff, ent_in;
   logic                del_ff, del_in;
   logic                sel;
   logic                hit;

   assign sel = (ptr == IDX_W'(INDEX));
   // delete point is at or above this slot
   assign hit = del_above | (ent_ff.val == ctrl.maxv);

   always_comb begin
      ent_in = ent_ff;
      del_in = del_ff;
      unique case (ctrl.mode)
         mstk_pkg::CELL_HOLD: begin
         end
         mstk_pkg::CELL_PUSH: begin
            ent_in = above;
         end
         mstk_pkg::CELL_POP: begin
            ent_in = below;
         end
         mstk_pkg::CELL_DOWN: begin
            if (sel) begin
               del_in = hit;
               if (hit) begin
                  ent_in = below;
               end
            end
         end
         mstk_pkg::CELL_UP: begin
            if (sel) begin
               ent_in.mx = (ctrl.bottom || (ent_ff.val > below.mx)) ? ent_ff.val : below.mx;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         del_ff <= 1'b0;
      end else begin
         del_ff <= del_in;
      end
   end

   assign ent = ent_ff;
   assign del = del_ff;

endmodule
